// ----- hw/rtl/rmth_pkg.sv -----
// Package for the running median block: sizes, widths and sequencer states.
// Used by the heap engine and the top level.
package rmth_pkg;
  localparam int unsigned Capacity  = 1024;
  localparam int unsigned HeapDepth = (Capacity + 1) / 2;
  localparam int unsigned AddrW     = $clog2(HeapDepth);
  localparam int unsigned SizeW     = $clog2(HeapDepth + 1);
  localparam int unsigned CountW    = 11;
  localparam int unsigned DataW     = 32;
  localparam int unsigned MedW      = 33;

  typedef logic [SizeW-1:0] size_t;
  typedef logic [AddrW-1:0] addr_t;

  // Heap engine operations.
  typedef enum logic [1:0] {
    OP_PUSH,
    OP_POP
  } heap_op_e;

  typedef enum logic [3:0] {
    HS_IDLE,
    HS_PUSH_RD,
    HS_PUSH_CMP,
    HS_POP_LAST,
    HS_POP_LASTW,
    HS_POP_RDL,
    HS_POP_RDR,
    HS_POP_CMP,
    HS_DONE
  } heap_state_e;

  typedef enum logic [3:0] {
    TS_IDLE,
    TS_DECIDE,
    TS_OP1,
    TS_WAIT1,
    TS_OP2,
    TS_WAIT2,
    TS_TOPS,
    TS_TOPSW,
    TS_OUT
  } top_state_e;

  typedef struct packed {
    logic     start;
    heap_op_e op;
    logic signed [DataW-1:0] value;
  } heap_req_t;

  typedef struct packed {
    logic done;
    logic signed [DataW-1:0] popped;
    logic signed [DataW-1:0] top;
    size_t size;
  } heap_rsp_t;
endpackage

// ----- hw/rtl/rmth_in_if.sv -----
// Input channel: valid/ready with one signed sample word.
// No dependencies.
interface rmth_in_if;
  logic valid;
  logic ready;
  logic signed [31:0] sample;
  modport source (output valid, output sample, input ready);
  modport sink (input valid, input sample, output ready);
endinterface

// ----- hw/rtl/rmth_out_if.sv -----
// Output channel: valid/ready with doubled median, count and drop flag.
// No dependencies.
interface rmth_out_if;
  logic valid;
  logic ready;
  logic signed [32:0] median_twice;
  logic [10:0] count;
  logic dropped;
  modport source (output valid, output median_twice, output count, output dropped,
                  input ready);
  modport sink (input valid, input median_twice, input count, input dropped,
                output ready);
endinterface

// ----- hw/rtl/rmth_ram.sv -----
// Generic single-port RAM with registered read.
// No dependencies.
module rmth_ram #(
  parameter int unsigned Width = 32,
  parameter int unsigned Depth = 512
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] addr_i,
  input  logic [Width-1:0]         wdata_i,
  output logic [Width-1:0]         rdata_o
);
  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[addr_i] <= wdata_i;
    end
    rdata_o <= mem[addr_i];
  end
endmodule

// ----- hw/rtl/rmth_heap.sv -----
// One binary heap (max or min) in a RAM, with a push/pop sequencer.
// Depends on rmth_pkg and rmth_ram. The top entry is mirrored in a register.
module rmth_heap (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                is_max_i,
  input  rmth_pkg::heap_req_t req_i,
  output rmth_pkg::heap_rsp_t rsp_o
);
  import rmth_pkg::*;

  heap_state_e state_q, state_d;
  size_t size_q, size_d;
  addr_t idx_q, idx_d, best_q, best_d;
  logic signed [DataW-1:0] val_q, val_d, bestv_q, bestv_d, top_q, top_d;
  logic signed [DataW-1:0] popped_q, popped_d;
  logic we;
  addr_t addr;
  logic signed [DataW-1:0] wdata, rdata;
  addr_t parent, lchild, rchild;
  logic [SizeW:0] lwide, rwide;

  rmth_ram #(.Width(DataW), .Depth(HeapDepth)) u_ram (
    .clk_i, .we_i(we), .addr_i(addr), .wdata_i(wdata), .rdata_o(rdata)
  );

  function automatic logic above(logic is_max, logic signed [DataW-1:0] a,
                                 logic signed [DataW-1:0] b);
    return is_max ? (a > b) : (a < b);
  endfunction

  assign parent = AddrW'((idx_q - addr_t'(1)) >> 1);
  assign lwide  = (SizeW+1)'({idx_q, 1'b1});
  assign rwide  = lwide + (SizeW+1)'(1);
  assign lchild = lwide[AddrW-1:0];
  assign rchild = rwide[AddrW-1:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= HS_IDLE;
      size_q  <= '0;
    end else begin
      state_q <= state_d;
      size_q  <= size_d;
    end
  end

  always_ff @(posedge clk_i) begin
    idx_q <= idx_d; best_q <= best_d; val_q <= val_d;
    bestv_q <= bestv_d; top_q <= top_d; popped_q <= popped_d;
  end

  // Push sifts the new value up by moving parents down (hole method);
  // pop sifts the last entry down from the root the same way.
  always_comb begin
    state_d = state_q; size_d = size_q; idx_d = idx_q; best_d = best_q;
    val_d = val_q; bestv_d = bestv_q; top_d = top_q; popped_d = popped_q;
    we = 1'b0; addr = idx_q; wdata = val_q;
    unique case (state_q)
      HS_IDLE: begin
        if (req_i.start) begin
          if (req_i.op == OP_PUSH) begin
            if (size_q < size_t'(HeapDepth)) begin
              val_d  = req_i.value;
              idx_d  = size_q[AddrW-1:0];
              size_d = size_q + size_t'(1);
              state_d = HS_PUSH_RD;
            end else begin
              state_d = HS_DONE;
            end
          end else if (size_q != '0) begin
            popped_d = top_q;
            size_d   = size_q - size_t'(1);
            idx_d    = '0;
            state_d  = HS_POP_LAST;
          end else begin
            popped_d = '0;
            state_d  = HS_DONE;
          end
        end
      end
      HS_PUSH_RD: begin
        if (idx_q == '0) begin
          we = 1'b1; top_d = val_q; state_d = HS_DONE;
        end else begin
          addr = parent;
          state_d = HS_PUSH_CMP;
        end
      end
      HS_PUSH_CMP: begin
        if (above(is_max_i, val_q, rdata)) begin
          we = 1'b1; wdata = rdata;
          idx_d = parent;
          state_d = HS_PUSH_RD;
        end else begin
          we = 1'b1;
          state_d = HS_DONE;
        end
      end
      HS_POP_LAST: begin
        addr = size_q[AddrW-1:0];
        state_d = HS_POP_LASTW;
      end
      HS_POP_LASTW: begin
        val_d = rdata;
        state_d = (size_q == '0) ? HS_DONE : HS_POP_RDL;
      end
      HS_POP_RDL: begin
        if (lwide < (SizeW+1)'(size_q)) begin
          addr = lchild;
          state_d = HS_POP_RDR;
        end else begin
          we = 1'b1;
          if (idx_q == '0) top_d = val_q;
          state_d = HS_DONE;
        end
      end
      HS_POP_RDR: begin
        best_d = lchild; bestv_d = rdata;
        addr = rchild;
        state_d = HS_POP_CMP;
      end
      HS_POP_CMP: begin
        if (rwide < (SizeW+1)'(size_q) && above(is_max_i, rdata, bestv_q)) begin
          bestv_d = rdata; best_d = rchild;
        end
        if (rwide < (SizeW+1)'(size_q) && above(is_max_i, rdata, bestv_q)) begin
          if (above(is_max_i, rdata, val_q)) begin
            we = 1'b1; wdata = rdata;
            if (idx_q == '0) top_d = rdata;
            idx_d = rchild; state_d = HS_POP_RDL;
          end else begin
            we = 1'b1;
            if (idx_q == '0) top_d = val_q;
            state_d = HS_DONE;
          end
        end else if (above(is_max_i, bestv_q, val_q)) begin
          we = 1'b1; wdata = bestv_q;
          if (idx_q == '0) top_d = bestv_q;
          idx_d = best_q; state_d = HS_POP_RDL;
        end else begin
          we = 1'b1;
          if (idx_q == '0) top_d = val_q;
          state_d = HS_DONE;
        end
      end
      HS_DONE: state_d = HS_IDLE;
      default: state_d = HS_IDLE;
    endcase
  end

  assign rsp_o.done   = (state_q == HS_DONE);
  assign rsp_o.popped = popped_q;
  assign rsp_o.top    = top_q;
  assign rsp_o.size   = size_q;
endmodule

// ----- hw/rtl/running_median_two_heaps.sv -----
// Running median over two RAM-based heaps. One word in, one word out.
// The time from acceptance to result is set by up to one pop and two pushes,
// each walking one heap level at a time through the heap RAM.
// One word at a time; the next is accepted after the result is taken.
// Reset (asynchronous, active low) empties both heaps; RAM contents are kept.
module running_median_two_heaps (
  input logic clk_i,
  input logic rst_ni,
  rmth_in_if.sink    in_i,
  rmth_out_if.source out_o
);
  import rmth_pkg::*;

  top_state_e state_q, state_d;
  logic signed [DataW-1:0] v_q, v_d;
  heap_req_t lreq, ureq;
  heap_rsp_t lrsp, ursp;
  // Plan: first op on which heap, then pushes.
  logic pop_lo_q, pop_lo_d, pop_up_q, pop_up_d, push_lo_q, push_lo_d;
  logic push_up_q, push_up_d, drop_q, drop_d;
  // Sticky completion flags for the two parallel pushes.
  logic ldone_q, ldone_d, udone_q, udone_d;
  logic signed [MedW-1:0] med_q, med_d;
  logic [CountW-1:0] cnt_q, cnt_d;
  logic [CountW-1:0] total;
  logic signed [DataW-1:0] moved;

  rmth_heap u_lower (.clk_i, .rst_ni, .is_max_i(1'b1), .req_i(lreq), .rsp_o(lrsp));
  rmth_heap u_upper (.clk_i, .rst_ni, .is_max_i(1'b0), .req_i(ureq), .rsp_o(ursp));

  assign total = CountW'(lrsp.size) + CountW'(ursp.size);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) state_q <= TS_IDLE;
    else state_q <= state_d;
  end

  always_ff @(posedge clk_i) begin
    v_q <= v_d; pop_lo_q <= pop_lo_d; pop_up_q <= pop_up_d;
    push_lo_q <= push_lo_d; push_up_q <= push_up_d; drop_q <= drop_d;
    med_q <= med_d; cnt_q <= cnt_d;
    ldone_q <= ldone_d; udone_q <= udone_d;
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      TS_IDLE:   if (in_i.valid) state_d = TS_DECIDE;
      TS_DECIDE: state_d = (total >= CountW'(Capacity)) ? TS_TOPS : TS_OP1;
      TS_OP1:    state_d = TS_WAIT1;
      TS_WAIT1:  if (pop_lo_q ? lrsp.done :
                     (pop_up_q ? ursp.done : (push_lo_q ? lrsp.done : ursp.done)))
                   state_d = TS_OP2;
      TS_OP2:    state_d = (push_lo_q && push_up_q) ? TS_WAIT2 : TS_TOPS;
      TS_WAIT2:  if ((ldone_q || lrsp.done) && (udone_q || ursp.done))
                   state_d = TS_TOPS;
      TS_TOPS:   state_d = TS_TOPSW;
      TS_TOPSW:  state_d = TS_OUT;
      TS_OUT:    if (out_o.ready) state_d = TS_IDLE;
      default:   state_d = TS_IDLE;
    endcase
  end

  // Pops come first (moved value registered by the heap), then the two pushes.
  assign moved = pop_lo_q ? lrsp.popped : ursp.popped;

  always_comb begin
    v_d = v_q; pop_lo_d = pop_lo_q; pop_up_d = pop_up_q; push_lo_d = push_lo_q;
    push_up_d = push_up_q; drop_d = drop_q; med_d = med_q; cnt_d = cnt_q;
    ldone_d = ldone_q | lrsp.done;
    udone_d = udone_q | ursp.done;
    lreq = '{start: 1'b0, op: OP_PUSH, value: v_q};
    ureq = '{start: 1'b0, op: OP_PUSH, value: v_q};
    unique case (state_q)
      TS_IDLE: if (in_i.valid) v_d = in_i.sample;
      TS_DECIDE: begin
        drop_d = (total >= CountW'(Capacity));
        pop_lo_d = 1'b0; pop_up_d = 1'b0; push_lo_d = 1'b0; push_up_d = 1'b0;
        if (total == '0) push_lo_d = 1'b1;
        else if (lrsp.size == '0) begin
          if (ursp.top >= v_q) push_lo_d = 1'b1;
          else begin pop_up_d = 1'b1; push_lo_d = 1'b1; push_up_d = 1'b1; end
        end else if (ursp.size == '0) begin
          if (lrsp.top <= v_q) push_up_d = 1'b1;
          else begin pop_lo_d = 1'b1; push_lo_d = 1'b1; push_up_d = 1'b1; end
        end else if (v_q >= lrsp.top && v_q <= ursp.top) begin
          if (lrsp.size > ursp.size) push_up_d = 1'b1;
          else push_lo_d = 1'b1;
        end else if (v_q < lrsp.top) begin
          push_lo_d = 1'b1;
          if (lrsp.size > ursp.size) begin pop_lo_d = 1'b1; push_up_d = 1'b1; end
        end else begin
          push_up_d = 1'b1;
          if (ursp.size > lrsp.size) begin pop_up_d = 1'b1; push_lo_d = 1'b1; end
        end
      end
      TS_OP1: begin
        if (pop_lo_q) lreq = '{start: 1'b1, op: OP_POP, value: v_q};
        else if (pop_up_q) ureq = '{start: 1'b1, op: OP_POP, value: v_q};
        else if (push_lo_q) lreq = '{start: 1'b1, op: OP_PUSH, value: v_q};
        else ureq = '{start: 1'b1, op: OP_PUSH, value: v_q};
      end
      TS_OP2: begin
        ldone_d = 1'b0;
        udone_d = 1'b0;
        // After a pop both pushes run at once on separate heaps.
        if (pop_lo_q) begin
          ureq = '{start: 1'b1, op: OP_PUSH, value: moved};
          lreq = '{start: 1'b1, op: OP_PUSH, value: v_q};
        end else if (pop_up_q) begin
          lreq = '{start: 1'b1, op: OP_PUSH, value: moved};
          ureq = '{start: 1'b1, op: OP_PUSH, value: v_q};
        end
      end
      TS_TOPSW: begin
        cnt_d = total;
        if (total == '0) med_d = '0;
        else if (lrsp.size > ursp.size) med_d = MedW'(lrsp.top) <<< 1;
        else if (ursp.size > lrsp.size) med_d = MedW'(ursp.top) <<< 1;
        else med_d = MedW'(lrsp.top) + MedW'(ursp.top);
      end
      default: ;
    endcase
  end

  assign in_i.ready         = (state_q == TS_IDLE);
  assign out_o.valid        = (state_q == TS_OUT);
  assign out_o.median_twice = med_q;
  assign out_o.count        = cnt_q;
  assign out_o.dropped      = drop_q;
endmodule
